@@ rtl/evm_pkg.sv @@
// ============================================================================
// Elliptical vignette mask package
// Shared widths, register indexes, data types and arithmetic helpers.
// ============================================================================
package evm_pkg;

    localparam int COORD_BITS     = 12;
    localparam int HALF_BITS      = 12;
    localparam int RATIO_BITS     = 17;
    localparam int FRAC_BITS      = 8;
    localparam int DIST_BITS      = 24;
    localparam int RECIP_BITS     = 32;
    localparam int ALPHA_BITS     = 8;
    localparam int FACT_BITS      = 17;
    localparam int FACT_SHIFT     = 16;
    localparam int SQUARE_FRAC    = 32;
    localparam int RATIO_FRAC     = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = RATIO_BITS;

    localparam int FOLD_BITS  = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 1;
    localparam int LEG_BITS   = DIST_BITS + 1;
    localparam int SQ_BITS    = 2 * LEG_BITS;
    localparam int ROOT_BITS  = LEG_BITS + 1;
    localparam int RAD_BITS   = 2 * ROOT_BITS;
    localparam int DSQ_BITS   = 2 * HALF_BITS;
    localparam int BIGR_BITS  = HALF_BITS + RATIO_BITS;
    localparam int T1_BITS    = DSQ_BITS + RATIO_BITS;
    localparam int ACC_BITS   = T1_BITS + RATIO_BITS;
    localparam int MUL_A_BITS = 32;
    localparam int MUL_P_BITS = MUL_A_BITS + LEG_BITS;
    localparam int PROD_BITS  = DIST_BITS + RECIP_BITS;
    localparam int FSQ_BITS   = 2 * FACT_BITS;
    localparam int SCALE_BITS = FSQ_BITS + ALPHA_BITS;
    localparam int DIV_CNT_BITS = $clog2(RECIP_BITS + 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHT_RATIO = 2'd2;

    localparam logic [HALF_BITS-1:0]  HALF_WIDTH_RESET   = 12'd320;
    localparam logic [HALF_BITS-1:0]  HALF_HEIGHT_RESET  = 12'd240;
    localparam logic [RATIO_BITS-1:0] BRIGHT_RATIO_RESET = 17'd52429;
    localparam logic [RATIO_BITS-1:0] RATIO_ONE          = 17'h10000;
    localparam logic [FACT_BITS-1:0]  FACT_ONE           = 17'h10000;

    localparam logic [RAD_BITS-1:0] SQRT_FIRST_BIT = {2'b01, {(RAD_BITS - 2){1'b0}}};
    localparam logic [RAD_BITS-1:0] SQRT_LAST_BIT  = {{(RAD_BITS - 1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [HALF_BITS-1:0]  half_w;
        logic [HALF_BITS-1:0]  half_h;
        logic                  axis_y;
        logic [DIST_BITS-1:0]  focus;
        logic [DIST_BITS-1:0]  min_sum;
        logic [DIST_BITS-1:0]  max_sum;
        logic [RECIP_BITS-1:0] recip;
    } evm_consts_t;

    typedef struct packed {
        logic [LEG_BITS-1:0] p;
        logic [LEG_BITS-1:0] q;
        logic [LEG_BITS-1:0] perp;
    } evm_legs_t;

    typedef struct packed {
        logic [RAD_BITS-1:0] rem;
        logic [RAD_BITS-1:0] root;
    } evm_sqrt_t;

    typedef enum logic [3:0] {
        D_IDLE,
        D_PREP,
        D_MUL_A,
        D_MUL_B,
        D_MUL_C,
        D_ROOT_F,
        D_LEGS,
        D_SQ_PERP,
        D_SQ_P,
        D_SQ_Q,
        D_ROOT_1,
        D_ROOT_2,
        D_SPAN,
        D_DIV
    } evm_dstate_t;

    // Legs of the two focal distances for a folded offset.
    function automatic evm_legs_t evm_make_legs(
        input logic [HALF_BITS-1:0] off_x,
        input logic [HALF_BITS-1:0] off_y,
        input logic [DIST_BITS-1:0] focus,
        input logic                 axis_y
    );
        logic [LEG_BITS-1:0] a;
        logic [LEG_BITS-1:0] b;
        logic [LEG_BITS-1:0] f;
        logic [LEG_BITS-1:0] along;
        evm_legs_t           legs;
        a         = LEG_BITS'({off_x, {FRAC_BITS{1'b0}}});
        b         = LEG_BITS'({off_y, {FRAC_BITS{1'b0}}});
        f         = LEG_BITS'(focus);
        along     = axis_y ? b : a;
        legs.perp = axis_y ? a : b;
        legs.p    = (along >= f) ? (along - f) : (f - along);
        legs.q    = along + f;
        return legs;
    endfunction

    // One digit of the bitwise integer square root.
    function automatic evm_sqrt_t evm_sqrt_step(
        input evm_sqrt_t           cur,
        input logic [RAD_BITS-1:0] sbit
    );
        logic [RAD_BITS-1:0] trial;
        evm_sqrt_t           nxt;
        trial = cur.root + sbit;
        if (cur.rem >= trial)
        begin
            nxt.rem  = cur.rem - trial;
            nxt.root = (cur.root >> 1) + sbit;
        end
        else
        begin
            nxt.rem  = cur.rem;
            nxt.root = cur.root >> 1;
        end
        return nxt;
    endfunction

endpackage

@@ rtl/evm_derive.sv @@
// ============================================================================
// Elliptical vignette mask constant sequencer
// Holds the configuration registers and recomputes the focal offset, the
// ellipse and corner distance sums and the span reciprocal after reset and
// after every register write, with one shared multiplier, an iterative
// square root and a restoring divider.
// ============================================================================
module evm_derive (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [evm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [evm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output evm_pkg::evm_consts_t                 consts,
    output logic                                 busy
);
    import evm_pkg::*;

    evm_dstate_t state_reg;
    evm_dstate_t state_next;

    logic [HALF_BITS-1:0]    hw_reg;
    logic [HALF_BITS-1:0]    hh_reg;
    logic [RATIO_BITS-1:0]   ratio_reg;

    logic [RATIO_BITS-1:0]   r_reg;
    logic [DSQ_BITS-1:0]     dsq_reg;
    logic [HALF_BITS-1:0]    ci_reg;
    logic [HALF_BITS-1:0]    cj_reg;
    logic                    axis_reg;
    logic [T1_BITS-1:0]      t1_reg;
    logic [ACC_BITS-1:0]     acc_reg;
    evm_legs_t               legs_reg;
    logic [SQ_BITS-1:0]      perpsq_reg;
    logic [SQ_BITS-1:0]      psq_reg;
    logic [SQ_BITS-1:0]      qsq_reg;
    evm_sqrt_t               sq_reg;
    logic [RAD_BITS-1:0]     sbit_reg;
    logic [ROOT_BITS-1:0]    d1_reg;
    logic [DIST_BITS-1:0]    span_reg;
    logic [DIST_BITS-1:0]    drem_reg;
    logic [RECIP_BITS:0]     quo_reg;
    logic [DIV_CNT_BITS-1:0] dcnt_reg;
    logic [DIST_BITS-1:0]    focus_reg;
    logic [DIST_BITS-1:0]    min_reg;
    logic [DIST_BITS-1:0]    max_reg;
    logic [RECIP_BITS-1:0]   recip_reg;

    logic                    cfg_hit;
    logic [RATIO_BITS-1:0]   r_sat;
    logic [DSQ_BITS-1:0]     hw_sq;
    logic [DSQ_BITS-1:0]     hh_sq;
    logic [HALF_BITS-1:0]    big;
    logic [BIGR_BITS-1:0]    big_r;
    logic [MUL_A_BITS-1:0]   mul_a;
    logic [LEG_BITS-1:0]     mul_b;
    logic [MUL_P_BITS-1:0]   mul_out;
    logic [ACC_BITS-1:0]     acc_sum;
    evm_sqrt_t               sq_step;
    logic                    root_done;
    logic [ROOT_BITS:0]      dist_total;
    logic                    div_bit;
    logic [DIST_BITS:0]      div_shift;
    logic                    div_ge;
    logic [DIST_BITS:0]      div_rem;
    logic [RECIP_BITS:0]     quo_new;

    assign cfg_hit = cfg_write && (cfg_index == REG_HALF_WIDTH ||
                                   cfg_index == REG_HALF_HEIGHT ||
                                   cfg_index == REG_BRIGHT_RATIO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg    <= HALF_WIDTH_RESET;
            hh_reg    <= HALF_HEIGHT_RESET;
            ratio_reg <= BRIGHT_RATIO_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HALF_WIDTH:   hw_reg    <= cfg_data[HALF_BITS-1:0];
                REG_HALF_HEIGHT:  hh_reg    <= cfg_data[HALF_BITS-1:0];
                REG_BRIGHT_RATIO: ratio_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        r_sat   = (ratio_reg > RATIO_ONE) ? RATIO_ONE : ratio_reg;
        hw_sq   = DSQ_BITS'(hw_reg) * DSQ_BITS'(hw_reg);
        hh_sq   = DSQ_BITS'(hh_reg) * DSQ_BITS'(hh_reg);
        big     = (hw_reg > hh_reg) ? hw_reg : hh_reg;
        big_r   = BIGR_BITS'(big) * BIGR_BITS'(r_sat);

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            D_MUL_A:
            begin
                mul_a = MUL_A_BITS'(dsq_reg);
                mul_b = LEG_BITS'(r_reg);
            end
            D_MUL_B:
            begin
                mul_a = MUL_A_BITS'(t1_reg[DSQ_BITS-1:0]);
                mul_b = LEG_BITS'(r_reg);
            end
            D_MUL_C:
            begin
                mul_a = MUL_A_BITS'(t1_reg[T1_BITS-1:DSQ_BITS]);
                mul_b = LEG_BITS'(r_reg);
            end
            D_SQ_PERP:
            begin
                mul_a = MUL_A_BITS'(legs_reg.perp);
                mul_b = legs_reg.perp;
            end
            D_SQ_P:
            begin
                mul_a = MUL_A_BITS'(legs_reg.p);
                mul_b = legs_reg.p;
            end
            D_SQ_Q:
            begin
                mul_a = MUL_A_BITS'(legs_reg.q);
                mul_b = legs_reg.q;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_out = MUL_P_BITS'(mul_a) * MUL_P_BITS'(mul_b);
        acc_sum = acc_reg + (ACC_BITS'(mul_out) << DSQ_BITS);

        sq_step    = evm_sqrt_step(sq_reg, sbit_reg);
        root_done  = (sbit_reg == SQRT_LAST_BIT);
        dist_total = {1'b0, d1_reg} + {1'b0, sq_step.root[ROOT_BITS-1:0]};

        div_bit   = (dcnt_reg == DIV_CNT_BITS'(RECIP_BITS));
        div_shift = {drem_reg, div_bit};
        div_ge    = (div_shift >= {1'b0, span_reg});
        div_rem   = div_ge ? (div_shift - {1'b0, span_reg}) : div_shift;
        quo_new   = {quo_reg[RECIP_BITS-1:0], div_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_PREP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:    state_next = D_IDLE;
            D_PREP:    state_next = D_MUL_A;
            D_MUL_A:   state_next = D_MUL_B;
            D_MUL_B:   state_next = D_MUL_C;
            D_MUL_C:   state_next = D_ROOT_F;
            D_ROOT_F:  state_next = root_done ? D_LEGS : D_ROOT_F;
            D_LEGS:    state_next = D_SQ_PERP;
            D_SQ_PERP: state_next = D_SQ_P;
            D_SQ_P:    state_next = D_SQ_Q;
            D_SQ_Q:    state_next = D_ROOT_1;
            D_ROOT_1:  state_next = root_done ? D_ROOT_2 : D_ROOT_1;
            D_ROOT_2:  state_next = root_done ? D_SPAN : D_ROOT_2;
            D_SPAN:    state_next = (max_reg > min_reg) ? D_DIV : D_IDLE;
            D_DIV:     state_next = (dcnt_reg == '0) ? D_IDLE : D_DIV;
            default:   state_next = D_IDLE;
        endcase
        if (cfg_hit)
        begin
            state_next = D_PREP;
        end
        busy = (state_reg != D_IDLE);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_PREP:
            begin
                r_reg    <= r_sat;
                dsq_reg  <= (hw_reg >= hh_reg) ? (hw_sq - hh_sq) : (hh_sq - hw_sq);
                min_reg  <= DIST_BITS'(big_r >> (FRAC_BITS - 1));
                axis_reg <= (hh_reg > hw_reg);
                ci_reg   <= (hw_reg != '0) ? (hw_reg - HALF_BITS'(1)) : '0;
                cj_reg   <= (hh_reg != '0) ? (hh_reg - HALF_BITS'(1)) : '0;
            end
            D_MUL_A:
            begin
                t1_reg <= mul_out[T1_BITS-1:0];
            end
            D_MUL_B:
            begin
                acc_reg <= ACC_BITS'(mul_out);
            end
            D_MUL_C:
            begin
                sq_reg.rem  <= RAD_BITS'(acc_sum[ACC_BITS-1:RATIO_FRAC]);
                sq_reg.root <= '0;
                sbit_reg    <= SQRT_FIRST_BIT;
            end
            D_ROOT_F:
            begin
                sq_reg   <= sq_step;
                sbit_reg <= sbit_reg >> 2;
                if (root_done)
                begin
                    focus_reg <= sq_step.root[DIST_BITS-1:0];
                end
            end
            D_LEGS:
            begin
                legs_reg <= evm_make_legs(ci_reg, cj_reg, focus_reg, axis_reg);
            end
            D_SQ_PERP:
            begin
                perpsq_reg <= mul_out[SQ_BITS-1:0];
            end
            D_SQ_P:
            begin
                psq_reg <= mul_out[SQ_BITS-1:0];
            end
            D_SQ_Q:
            begin
                qsq_reg     <= mul_out[SQ_BITS-1:0];
                sq_reg.rem  <= RAD_BITS'(psq_reg) + RAD_BITS'(perpsq_reg);
                sq_reg.root <= '0;
                sbit_reg    <= SQRT_FIRST_BIT;
            end
            D_ROOT_1:
            begin
                if (root_done)
                begin
                    d1_reg      <= sq_step.root[ROOT_BITS-1:0];
                    sq_reg.rem  <= RAD_BITS'(qsq_reg) + RAD_BITS'(perpsq_reg);
                    sq_reg.root <= '0;
                    sbit_reg    <= SQRT_FIRST_BIT;
                end
                else
                begin
                    sq_reg   <= sq_step;
                    sbit_reg <= sbit_reg >> 2;
                end
            end
            D_ROOT_2:
            begin
                sq_reg   <= sq_step;
                sbit_reg <= sbit_reg >> 2;
                if (root_done)
                begin
                    max_reg <= dist_total[DIST_BITS-1:0];
                end
            end
            D_SPAN:
            begin
                span_reg <= max_reg - min_reg;
                drem_reg <= '0;
                quo_reg  <= '0;
                dcnt_reg <= DIV_CNT_BITS'(RECIP_BITS);
                if (max_reg <= min_reg)
                begin
                    recip_reg <= '0;
                end
            end
            D_DIV:
            begin
                drem_reg <= div_rem[DIST_BITS-1:0];
                quo_reg  <= quo_new;
                dcnt_reg <= dcnt_reg - DIV_CNT_BITS'(1);
                if (dcnt_reg == '0)
                begin
                    recip_reg <= quo_new[RECIP_BITS] ? '1 : quo_new[RECIP_BITS-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign consts.half_w  = hw_reg;
    assign consts.half_h  = hh_reg;
    assign consts.axis_y  = axis_reg;
    assign consts.focus   = focus_reg;
    assign consts.min_sum = min_reg;
    assign consts.max_sum = max_reg;
    assign consts.recip   = recip_reg;

endmodule

@@ rtl/evm_front.sv @@
// ============================================================================
// Elliptical vignette mask front end
// Three stages: quadrant fold and focal legs, leg squares, and the two
// radicands of the focal distances.
// ============================================================================
module evm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_take,
    input  logic [evm_pkg::COORD_BITS-1:0]    pixel_x,
    input  logic [evm_pkg::COORD_BITS-1:0]    pixel_y,
    input  evm_pkg::evm_consts_t              consts,
    output logic                              out_valid,
    output logic                              out_ok,
    output logic [evm_pkg::RAD_BITS-1:0]      out_rad1,
    output logic [evm_pkg::RAD_BITS-1:0]      out_rad2
);
    import evm_pkg::*;

    logic [FOLD_BITS-1:0] cx;
    logic [FOLD_BITS-1:0] cy;
    logic [FOLD_BITS-1:0] hx;
    logic [FOLD_BITS-1:0] hy;
    logic [FOLD_BITS-1:0] ox;
    logic [FOLD_BITS-1:0] oy;
    logic                 fold_ok;
    evm_legs_t            legs_in;

    logic                 v0_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 ok0_reg;
    logic                 ok1_reg;
    logic                 ok2_reg;
    evm_legs_t            legs0_reg;
    logic [SQ_BITS-1:0]   psq1_reg;
    logic [SQ_BITS-1:0]   qsq1_reg;
    logic [SQ_BITS-1:0]   perpsq1_reg;
    logic [RAD_BITS-1:0]  rad1_reg;
    logic [RAD_BITS-1:0]  rad2_reg;

    always_comb
    begin
        cx      = FOLD_BITS'(pixel_x);
        cy      = FOLD_BITS'(pixel_y);
        hx      = FOLD_BITS'(consts.half_w);
        hy      = FOLD_BITS'(consts.half_h);
        ox      = (cx >= hx) ? (cx - hx) : (hx - FOLD_BITS'(1) - cx);
        oy      = (cy >= hy) ? (cy - hy) : (hy - FOLD_BITS'(1) - cy);
        fold_ok = (ox < hx) && (oy < hy);
        legs_in = evm_make_legs(ox[HALF_BITS-1:0], oy[HALF_BITS-1:0],
                                consts.focus, consts.axis_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= in_take;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok0_reg     <= fold_ok;
            legs0_reg   <= legs_in;
            ok1_reg     <= ok0_reg;
            psq1_reg    <= SQ_BITS'(legs0_reg.p) * SQ_BITS'(legs0_reg.p);
            qsq1_reg    <= SQ_BITS'(legs0_reg.q) * SQ_BITS'(legs0_reg.q);
            perpsq1_reg <= SQ_BITS'(legs0_reg.perp) * SQ_BITS'(legs0_reg.perp);
            ok2_reg     <= ok1_reg;
            rad1_reg    <= RAD_BITS'(psq1_reg) + RAD_BITS'(perpsq1_reg);
            rad2_reg    <= RAD_BITS'(qsq1_reg) + RAD_BITS'(perpsq1_reg);
        end
    end

    assign out_valid = v2_reg;
    assign out_ok    = ok2_reg;
    assign out_rad1  = rad1_reg;
    assign out_rad2  = rad2_reg;

endmodule

@@ rtl/evm_root_pipe.sv @@
// ============================================================================
// Elliptical vignette mask square root pipeline
// Two lanes of bitwise integer square root, one result bit per stage.
// ============================================================================
module evm_root_pipe (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic                              in_ok,
    input  logic [evm_pkg::RAD_BITS-1:0]      in_rad1,
    input  logic [evm_pkg::RAD_BITS-1:0]      in_rad2,
    output logic                              out_valid,
    output logic                              out_ok,
    output logic [evm_pkg::ROOT_BITS-1:0]     out_root1,
    output logic [evm_pkg::ROOT_BITS-1:0]     out_root2
);
    import evm_pkg::*;

    logic [ROOT_BITS-1:0] valid_reg;
    logic [ROOT_BITS-1:0] ok_reg;
    evm_sqrt_t            lane1_reg [ROOT_BITS];
    evm_sqrt_t            lane2_reg [ROOT_BITS];
    evm_sqrt_t            lane1_next [ROOT_BITS];
    evm_sqrt_t            lane2_next [ROOT_BITS];
    evm_sqrt_t            src1;
    evm_sqrt_t            src2;

    always_comb
    begin
        for (int k = 0; k < ROOT_BITS; k++)
        begin
            if (k == 0)
            begin
                src1.rem  = in_rad1;
                src1.root = '0;
                src2.rem  = in_rad2;
                src2.root = '0;
            end
            else
            begin
                src1 = lane1_reg[k-1];
                src2 = lane2_reg[k-1];
            end
            lane1_next[k] = evm_sqrt_step(src1, SQRT_FIRST_BIT >> (2 * k));
            lane2_next[k] = evm_sqrt_step(src2, SQRT_FIRST_BIT >> (2 * k));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[ROOT_BITS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok_reg <= {ok_reg[ROOT_BITS-2:0], in_ok};
            for (int k = 0; k < ROOT_BITS; k++)
            begin
                lane1_reg[k] <= lane1_next[k];
                lane2_reg[k] <= lane2_next[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_BITS-1];
    assign out_ok    = ok_reg[ROOT_BITS-1];
    assign out_root1 = lane1_reg[ROOT_BITS-1].root[ROOT_BITS-1:0];
    assign out_root2 = lane2_reg[ROOT_BITS-1].root[ROOT_BITS-1:0];

endmodule

@@ rtl/evm_back.sv @@
// ============================================================================
// Elliptical vignette mask back end
// Distance sum, ellipse test and clamp, normalizing product, square of the
// factor and the final alpha scale in the output register.
// ============================================================================
module evm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              in_valid,
    input  logic                              in_ok,
    input  logic [evm_pkg::ROOT_BITS-1:0]     in_root1,
    input  logic [evm_pkg::ROOT_BITS-1:0]     in_root2,
    input  evm_pkg::evm_consts_t              consts,
    output logic                              out_valid,
    output logic [evm_pkg::ALPHA_BITS-1:0]    mask_alpha,
    output logic                              inside_ellipse
);
    import evm_pkg::*;

    logic [ROOT_BITS:0]              root_sum;
    logic [DIST_BITS-1:0]            clamped;
    logic [PROD_BITS-FACT_SHIFT-1:0] shifted;
    logic [FACT_BITS-1:0]            fact;
    logic [SCALE_BITS-1:0]           scaled;

    logic                  v0_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  out_valid_reg;
    logic                  ok0_reg;
    logic [DIST_BITS-1:0]  dsum0_reg;
    logic                  show1_reg;
    logic                  in1_reg;
    logic [DIST_BITS-1:0]  num1_reg;
    logic                  show2_reg;
    logic                  in2_reg;
    logic [PROD_BITS-1:0]  prod2_reg;
    logic                  show3_reg;
    logic                  in3_reg;
    logic [FSQ_BITS-1:0]   fsq3_reg;
    logic [ALPHA_BITS-1:0] alpha_reg;
    logic                  inside_reg;

    always_comb
    begin
        root_sum = {1'b0, in_root1} + {1'b0, in_root2};
        clamped  = (dsum0_reg > consts.max_sum) ? consts.max_sum : dsum0_reg;
        shifted  = prod2_reg[PROD_BITS-1:FACT_SHIFT];
        fact     = (shifted > (PROD_BITS - FACT_SHIFT)'(FACT_ONE)) ? FACT_ONE
                                                                  : shifted[FACT_BITS-1:0];
        scaled   = {fsq3_reg, {ALPHA_BITS{1'b0}}} - SCALE_BITS'(fsq3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= v0_reg;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok0_reg    <= in_ok;
            dsum0_reg  <= root_sum[DIST_BITS-1:0];

            in1_reg    <= ok0_reg && (dsum0_reg < consts.min_sum);
            show1_reg  <= ok0_reg && !(dsum0_reg < consts.min_sum);
            num1_reg   <= clamped - consts.min_sum;

            in2_reg    <= in1_reg;
            show2_reg  <= show1_reg;
            prod2_reg  <= PROD_BITS'(num1_reg) * PROD_BITS'(consts.recip);

            in3_reg    <= in2_reg;
            show3_reg  <= show2_reg;
            fsq3_reg   <= FSQ_BITS'(fact) * FSQ_BITS'(fact);

            inside_reg <= in3_reg;
            alpha_reg  <= show3_reg ? scaled[SQUARE_FRAC+ALPHA_BITS-1:SQUARE_FRAC] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mask_alpha     = alpha_reg;
    assign inside_ellipse = inside_reg;

endmodule

@@ rtl/elliptical_vignette_mask_unit.sv @@
// ============================================================================
// Elliptical vignette mask unit
// Gives the darkening alpha of an elliptical vignette for each pixel request.
// ============================================================================
// One pixel request is taken per clock while in_stall is low: three front
// stages fold the coordinate and form the squared focal legs, 26 square root
// stages extract both focal distances one bit per stage, and five back
// stages form the distance sum, normalize, square and scale it. A stall on a
// valid output freezes the whole pipeline. After reset and after every
// register write, a sequencer recomputes the focal offset, the two distance
// sums and the span reciprocal with three square roots of 26 steps and a
// 33-step divide, and in_stall stays high meanwhile.
module elliptical_vignette_mask_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [evm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [evm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [evm_pkg::COORD_BITS-1:0]       pixel_x,
    input  logic [evm_pkg::COORD_BITS-1:0]       pixel_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [evm_pkg::ALPHA_BITS-1:0]       mask_alpha,
    output logic                                 inside_ellipse
);
    import evm_pkg::*;

    evm_consts_t          consts;
    logic                 busy;
    logic                 advance;
    logic                 front_valid;
    logic                 front_ok;
    logic [RAD_BITS-1:0]  rad1;
    logic [RAD_BITS-1:0]  rad2;
    logic                 root_valid;
    logic                 root_ok;
    logic [ROOT_BITS-1:0] root1;
    logic [ROOT_BITS-1:0] root2;

    assign advance  = !(out_valid && out_stall);
    assign in_stall = busy || !advance;

    evm_derive u_derive (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .consts    (consts),
        .busy      (busy)
    );

    evm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_take   (in_valid && !busy),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .consts    (consts),
        .out_valid (front_valid),
        .out_ok    (front_ok),
        .out_rad1  (rad1),
        .out_rad2  (rad2)
    );

    evm_root_pipe u_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (front_valid),
        .in_ok     (front_ok),
        .in_rad1   (rad1),
        .in_rad2   (rad2),
        .out_valid (root_valid),
        .out_ok    (root_ok),
        .out_root1 (root1),
        .out_root2 (root2)
    );

    evm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_valid       (root_valid),
        .in_ok          (root_ok),
        .in_root1       (root1),
        .in_root2       (root2),
        .consts         (consts),
        .out_valid      (out_valid),
        .mask_alpha     (mask_alpha),
        .inside_ellipse (inside_ellipse)
    );

endmodule
